[rtl/core/urs_pkg.sv]
package urs_pkg;

    // Fixed field widths of the measurement channel.
    localparam int DIST_W    = 16;
    localparam int CFG_W     = 16;
    localparam int SENSOR_W  = 2;
    localparam int TRIG_W    = 3;
    localparam int NUM_VIEWS = 3;

    // Distance reported and stored when no echo came back in time.
    localparam logic [DIST_W-1:0] NO_ECHO = 16'hFFFF;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] PULSE_RESET   = 16'd3;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd10000;

    // Reset values of the distance store: sensor 0 reads 1, the rest read 0.
    localparam logic [DIST_W-1:0] DIST_RESET_FIRST = 16'd1;
    localparam logic [DIST_W-1:0] DIST_RESET_OTHER = 16'd0;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    // Phase of the ranging cycle.
    typedef enum logic [1:0] {
        PH_TRIGGER = 2'b01,
        PH_LISTEN  = 2'b10
    } t_phase;

    // What one tick produces, passed from the timer to the store and output.
    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_lines;
        logic                meas_valid;
        logic                meas_timeout;
        logic [SENSOR_W-1:0] meas_sensor;
        logic [DIST_W-1:0]   meas_distance;
    } t_meas;

    // One full result item as held in the output register.
    typedef struct packed {
        t_meas             meas;
        logic [DIST_W-1:0] left_distance;
        logic [DIST_W-1:0] center_distance;
        logic [DIST_W-1:0] right_distance;
    } t_out_item;

endpackage

[rtl/core/urs_in_if.sv]
interface urs_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

[rtl/core/urs_out_if.sv]
interface urs_out_if;
    logic                           valid;
    logic                           ready;
    logic [urs_pkg::TRIG_W-1:0]     trigger_lines;
    logic                           meas_valid;
    logic [urs_pkg::SENSOR_W-1:0]   meas_sensor;
    logic [urs_pkg::DIST_W-1:0]     meas_distance;
    logic                           meas_timeout;
    logic [urs_pkg::DIST_W-1:0]     left_distance;
    logic [urs_pkg::DIST_W-1:0]     center_distance;
    logic [urs_pkg::DIST_W-1:0]     right_distance;

    modport source (
        output valid, output trigger_lines, output meas_valid, output meas_sensor,
        output meas_distance, output meas_timeout, output left_distance,
        output center_distance, output right_distance, input ready
    );
    modport sink (
        input valid, input trigger_lines, input meas_valid, input meas_sensor,
        input meas_distance, input meas_timeout, input left_distance,
        input center_distance, input right_distance, output ready
    );
endinterface

[rtl/core/urs_timer.sv]
module urs_timer #(
    parameter int NUM_SENSORS = 3,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_echo,
    input  logic [urs_pkg::CFG_W-1:0]  i_pulse_ticks,
    input  logic [urs_pkg::CFG_W-1:0]  i_timeout_ticks,
    output urs_pkg::t_meas             o_meas
);
    localparam int DIFF_W = (COUNT_WIDTH > urs_pkg::DIST_W) ? COUNT_WIDTH : urs_pkg::DIST_W;
    localparam logic [urs_pkg::SENSOR_W-1:0] LAST_SENSOR =
        urs_pkg::SENSOR_W'(NUM_SENSORS - 1);

    urs_pkg::t_phase               r_phase, n_phase;
    logic                          r_expect_fall, n_expect_fall;
    logic                          r_capture_done, n_capture_done;
    logic [COUNT_WIDTH-1:0]        r_tick, n_tick;
    logic [COUNT_WIDTH-1:0]        r_stamp, n_stamp;
    logic [urs_pkg::SENSOR_W-1:0]  r_sensor, n_sensor;
    logic                          r_echo_prev;

    logic                          w_rise;
    logic                          w_fall;
    logic [COUNT_WIDTH-1:0]        w_pulse_cmp;
    logic [COUNT_WIDTH-1:0]        w_timeout_cmp;
    logic [DIFF_W-1:0]             w_diff;
    logic [urs_pkg::SENSOR_W-1:0]  w_next_sensor;
    logic                          w_captured;

    // Compare values keep only the counter's width.
    assign w_pulse_cmp   = COUNT_WIDTH'(i_pulse_ticks);
    assign w_timeout_cmp = COUNT_WIDTH'(i_timeout_ticks);

    assign w_rise = i_echo & ~r_echo_prev;
    assign w_fall = ~i_echo & r_echo_prev;

    // Echo width wraps at 16 bits.
    assign w_diff = DIFF_W'(r_tick) - DIFF_W'(r_stamp);

    // Round-robin sensor advance.
    assign w_next_sensor = (r_sensor == LAST_SENSOR) ? '0 : r_sensor + 1'b1;

    // Next-state and result logic for one tick.
    always_comb begin
        n_phase        = r_phase;
        n_expect_fall  = r_expect_fall;
        n_capture_done = r_capture_done;
        n_tick         = r_tick;
        n_stamp        = r_stamp;
        n_sensor       = r_sensor;
        w_captured     = 1'b0;
        o_meas         = '0;

        case (r_phase)
            urs_pkg::PH_TRIGGER: begin
                o_meas.trigger_lines = urs_pkg::TRIG_W'(4'b0001 << r_sensor);
                if (r_tick == w_pulse_cmp) begin
                    n_phase        = urs_pkg::PH_LISTEN;
                    n_tick         = '0;
                    n_capture_done = 1'b0;
                    n_expect_fall  = 1'b0;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            urs_pkg::PH_LISTEN: begin
                // Edge capture, ignored once a width has been taken.
                if (!r_capture_done) begin
                    if (!r_expect_fall && w_rise) begin
                        n_stamp       = r_tick;
                        n_expect_fall = 1'b1;
                    end else if (r_expect_fall && w_fall) begin
                        w_captured           = 1'b1;
                        n_capture_done       = 1'b1;
                        o_meas.meas_valid    = 1'b1;
                        o_meas.meas_sensor   = r_sensor;
                        o_meas.meas_distance = w_diff[urs_pkg::DIST_W-1:0];
                        n_sensor             = w_next_sensor;
                    end
                end
                // End of the listen window; a capture on this tick wins.
                if (r_tick == w_timeout_cmp) begin
                    if (!r_capture_done && !w_captured) begin
                        o_meas.meas_valid    = 1'b1;
                        o_meas.meas_timeout  = 1'b1;
                        o_meas.meas_sensor   = r_sensor;
                        o_meas.meas_distance = urs_pkg::NO_ECHO;
                        n_sensor             = w_next_sensor;
                    end
                    n_phase        = urs_pkg::PH_TRIGGER;
                    n_expect_fall  = 1'b0;
                    n_capture_done = 1'b0;
                    n_tick         = '0;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
            default: begin
                n_phase = urs_pkg::PH_TRIGGER;
                n_tick  = '0;
            end
        endcase
    end

    // State registers advance once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= urs_pkg::PH_TRIGGER;
            r_expect_fall  <= 1'b0;
            r_capture_done <= 1'b0;
            r_tick         <= '0;
            r_stamp        <= '0;
            r_sensor       <= '0;
            r_echo_prev    <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_expect_fall  <= n_expect_fall;
            r_capture_done <= n_capture_done;
            r_tick         <= n_tick;
            r_stamp        <= n_stamp;
            r_sensor       <= n_sensor;
            r_echo_prev    <= i_echo;
        end
    end

endmodule

[rtl/core/urs_store.sv]
module urs_store #(
    parameter int NUM_SENSORS = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  urs_pkg::t_meas             i_meas,
    output logic [urs_pkg::DIST_W-1:0] o_dist [urs_pkg::NUM_VIEWS]
);
    logic [urs_pkg::DIST_W-1:0] r_dist [NUM_SENSORS];
    logic [urs_pkg::DIST_W-1:0] n_dist [NUM_SENSORS];

    // One register per sensor; the recorded result overwrites its entry.
    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_entry
        assign n_dist[g] = (i_meas.meas_valid &&
                            i_meas.meas_sensor == urs_pkg::SENSOR_W'(g)) ?
                           i_meas.meas_distance : r_dist[g];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dist[g] <= (g == 0) ? urs_pkg::DIST_RESET_FIRST :
                                        urs_pkg::DIST_RESET_OTHER;
            end else if (i_step) begin
                r_dist[g] <= n_dist[g];
            end
        end
    end

    // Views show the distances after this tick; no sensor behind a view reads 0.
    for (genvar v = 0; v < urs_pkg::NUM_VIEWS; v++) begin : g_view
        if (v < NUM_SENSORS) begin : g_used
            assign o_dist[v] = n_dist[v];
        end else begin : g_unused
            assign o_dist[v] = '0;
        end
    end

endmodule

[rtl/core/ultrasonic_ranging_scanner.sv]
// Ultrasonic ranging scanner for up to three sensors (three views) sharing one
// echo line. Each request on the input channel is one timer tick carrying the
// sampled echo level; each tick yields exactly one result request carrying the
// trigger lines, any distance or timeout recorded on that tick, and the three
// stored distances after that tick. The block takes one tick per clock cycle
// when the output side keeps up; a result is offered once its tick has passed
// the input register, the tick logic and the result register. pulse_ticks and
// timeout_ticks are written through the configuration port; the user must do
// so only while no tick is in flight, as the block itself does not enforce it.
module ultrasonic_ranging_scanner #(
    parameter int NUM_SENSORS = 3,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [urs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urs_pkg::CFG_W-1:0]      i_cfg_data,
    urs_in_if.sink                         i_in,
    urs_out_if.source                      o_out
);
    logic [urs_pkg::CFG_W-1:0]  r_pulse_ticks;
    logic [urs_pkg::CFG_W-1:0]  r_timeout_ticks;
    logic                       r_in_valid;
    logic                       r_in_echo;
    logic                       r_out_valid;
    urs_pkg::t_out_item         r_out;

    logic                       w_step;
    urs_pkg::t_meas             w_meas;
    logic [urs_pkg::DIST_W-1:0] w_dist [urs_pkg::NUM_VIEWS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks   <= urs_pkg::PULSE_RESET;
            r_timeout_ticks <= urs_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                urs_pkg::CFG_PULSE_TICKS:   r_pulse_ticks   <= i_cfg_data;
                urs_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A held tick is processed when the result register is free or draining.
    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_echo <= i_in.echo_level;
        end
    end

    urs_timer #(
        .NUM_SENSORS (NUM_SENSORS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_echo          (r_in_echo),
        .i_pulse_ticks   (r_pulse_ticks),
        .i_timeout_ticks (r_timeout_ticks),
        .o_meas          (w_meas)
    );

    urs_store #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_meas  (w_meas),
        .o_dist  (w_dist)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.meas            <= w_meas;
            r_out.left_distance   <= w_dist[0];
            r_out.center_distance <= w_dist[1];
            r_out.right_distance  <= w_dist[2];
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.trigger_lines   = r_out.meas.trigger_lines;
    assign o_out.meas_valid      = r_out.meas.meas_valid;
    assign o_out.meas_sensor     = r_out.meas.meas_sensor;
    assign o_out.meas_distance   = r_out.meas.meas_distance;
    assign o_out.meas_timeout    = r_out.meas.meas_timeout;
    assign o_out.left_distance   = r_out.left_distance;
    assign o_out.center_distance = r_out.center_distance;
    assign o_out.right_distance  = r_out.right_distance;

endmodule

[rtl/core/urs_checker.sv]
module urs_props #(
    parameter int NUM_SENSORS = 3
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [urs_pkg::TRIG_W-1:0]     i_trigger_lines,
    input logic                           i_meas_valid,
    input logic [urs_pkg::SENSOR_W-1:0]   i_meas_sensor,
    input logic [urs_pkg::DIST_W-1:0]     i_meas_distance,
    input logic                           i_meas_timeout
);
    localparam logic [urs_pkg::SENSOR_W-1:0] LAST_SENSOR =
        urs_pkg::SENSOR_W'(NUM_SENSORS - 1);

    // At most one sensor is triggered, and never while a result is recorded.
    a_trigger_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($onehot0(i_trigger_lines) &&
                         (!i_meas_valid || i_trigger_lines == '0)))
        else $error("trigger active together with a measurement");

    // A timeout always carries the no-echo distance.
    a_timeout_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_meas_timeout) |->
            (i_meas_valid && i_meas_distance == urs_pkg::NO_ECHO))
        else $error("timeout without no-echo distance");

    // Recorded sensor is a real one; idle fields read zero.
    a_meas_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_meas_valid ? (i_meas_sensor <= LAST_SENSOR) :
                         (i_meas_sensor == '0 && i_meas_distance == '0)))
        else $error("measurement fields inconsistent");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_meas_distance) && $stable(i_meas_valid)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_ranging_scanner urs_props #(
    .NUM_SENSORS (NUM_SENSORS)
) u_urs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_trigger_lines (o_out.trigger_lines),
    .i_meas_valid    (o_out.meas_valid),
    .i_meas_sensor   (o_out.meas_sensor),
    .i_meas_distance (o_out.meas_distance),
    .i_meas_timeout  (o_out.meas_timeout)
);
